// File: rtl/core/window_mapping_table_unit_macros.svh
// ----------------------------------------------------------------------------
// window_mapping_table_unit_macros
// Assertion macros for the window mapping table unit.
// ----------------------------------------------------------------------------
`ifndef WINDOW_MAPPING_TABLE_UNIT_MACROS_SVH
`define WINDOW_MAPPING_TABLE_UNIT_MACROS_SVH
`define WMT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define WMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: rtl/core/wmt_pkg.sv
// ----------------------------------------------------------------------------
// wmt_pkg
// Shared types and constants of the window mapping table unit.
// ----------------------------------------------------------------------------
package wmt_pkg;
   localparam int SlotCountDefault = 512;
   localparam int MaxPagesDefault  = 63;
   localparam logic [31:0] IdentityLimitReset = 32'h0080_0000;
   localparam logic [31:0] KernelBaseReset    = 32'hC000_0000;
   localparam logic [31:0] WindowBaseReset    = 32'hE000_0000;
   localparam logic [31:0] WindowSizeReset    = 32'h1000_0000;

   localparam logic [1:0] CSR_IDENTITY_LIMIT = 2'd0;
   localparam logic [1:0] CSR_KERNEL_BASE    = 2'd1;
   localparam logic [1:0] CSR_WINDOW_BASE    = 2'd2;
   localparam logic [1:0] CSR_WINDOW_SIZE    = 2'd3;

   localparam logic OP_MAP    = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [2:0] ST_IDENTITY  = 3'd0;
   localparam logic [2:0] ST_EXISTING  = 3'd1;
   localparam logic [2:0] ST_NEW       = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_NO_SLOT   = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;
   localparam logic [2:0] ST_TOO_LARGE = 3'd6;

   typedef struct packed {
      logic        op;
      logic [31:0] paddr;
      logic [17:0] map_size;
      logic [4:0]  cache_flags;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] page_phys;
      logic [31:0] page_virt;
      logic [4:0]  pte_flags;
      logic [31:0] vaddr;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   // search token passed from cell to cell
   typedef struct packed {
      logic        live;
      logic        done;
      logic        hit;
      logic        free_found;
      logic [31:0] virt;
      logic [31:0] pa;
   } tok_type;

   // slot write from the sequencer
   typedef struct packed {
      logic        en;
      logic [31:0] phys;
      logic [31:0] virt;
      logic [17:0] len;
   } fill_type;
endpackage

// File: rtl/core/wmt_cell.sv
// ----------------------------------------------------------------------------
// wmt_cell
// One table slot: tests the passing token for a range hit and takes a fill.
// ----------------------------------------------------------------------------
module wmt_cell (
   input  logic              clock,
   input  logic              reset,
   input  wmt_pkg::tok_type  tok_i,
   input  logic              fill_mark_i,
   input  wmt_pkg::fill_type fill_i,
   output wmt_pkg::tok_type  tok_o,
   output logic              fill_mark_o
);
   logic        valid_ff;
   logic [31:0] phys_ff;
   logic [31:0] virt_ff;
   logic [17:0] len_ff;
   logic [32:0] end_w;
   logic        hit_w;
   wmt_pkg::tok_type tok_ff, tok_in;

   assign end_w = {1'b0, phys_ff} + {15'd0, len_ff};
   assign hit_w = valid_ff && (tok_i.pa >= phys_ff) && ({1'b0, tok_i.pa} < end_w);

   always_comb begin
      tok_in = tok_i;
      if (tok_i.live && !tok_i.done && hit_w) begin
         tok_in.done = 1'b1;
         tok_in.hit  = 1'b1;
         tok_in.virt = virt_ff + (tok_i.pa - phys_ff);
      end
      if (tok_i.live && !valid_ff) tok_in.free_found = 1'b1;
   end

   // used slots form a prefix: a free cell behind a used one is the first free cell
   assign fill_mark_o = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         tok_ff.live <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         if (fill_i.en && fill_mark_i && !valid_ff) begin
            valid_ff <= 1'b1;
            phys_ff  <= fill_i.phys;
            virt_ff  <= fill_i.virt;
            len_ff   <= fill_i.len;
         end
      end
   end
   assign tok_o = tok_ff;
endmodule

// File: rtl/core/wmt_chain.sv
// ----------------------------------------------------------------------------
// wmt_chain
// Row of slot cells; the token walks one cell per cycle.
// ----------------------------------------------------------------------------
module wmt_chain #(
   parameter int SLOT_COUNT = wmt_pkg::SlotCountDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  wmt_pkg::tok_type  tok_i,
   input  wmt_pkg::fill_type fill_i,
   output wmt_pkg::tok_type  tok_o
);
   wmt_pkg::tok_type tok_w [SLOT_COUNT+1];
   logic             mark_w [SLOT_COUNT+1];

   assign tok_w[0]  = tok_i;
   assign mark_w[0] = 1'b1;

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
      wmt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .tok_i       (tok_w[g]),
         .fill_mark_i (mark_w[g]),
         .fill_i      (fill_i),
         .tok_o       (tok_w[g+1]),
         .fill_mark_o (mark_w[g+1])
      );
   end
   assign tok_o = tok_w[SLOT_COUNT];
endmodule

// File: rtl/core/window_mapping_table_unit.sv
// ----------------------------------------------------------------------------
// window_mapping_table_unit
// Maps physical addresses to kernel virtual addresses through a slot row.
//
//  channel | dir | handshake      | word
//  req     | in  | valid / stall  | op, paddr, map_size, cache_flags
//  rsp     | out | valid / stall  | page write or final answer
//  csr     | in  | valid / ready  | register index, data
//
// Identity hits go from SEARCH straight to FINAL; other requests stay in
// SEARCH while the search token walks the cell row.
// A new map passes DECIDE, gives page writes in PAGES, one per cycle while
// rsp is not stalled, and then its final answer from FINAL.
// Reset is synchronous; the table clears at once, no clearing pass.
// A stalled rsp holds its word; one request is in flight at a time.
// ----------------------------------------------------------------------------
module window_mapping_table_unit #(
   parameter int SLOT_COUNT = wmt_pkg::SlotCountDefault,
   parameter int MAX_PAGES  = wmt_pkg::MaxPagesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wmt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wmt_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);
   typedef enum logic [2:0] {IDLE, SEARCH, DECIDE, PAGES, FINAL} state_type;

   state_type        state_ff;
   wmt_pkg::req_type req_ff;
   logic [31:0]      ilimit_ff, kbase_ff, wbase_ff, wsize_ff, nfv_ff;
   logic [6:0]       pages_ff, k_ff;
   logic [31:0]      virt_ff;
   logic [2:0]       status_ff;
   wmt_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;
   wmt_pkg::tok_type tok_in, tok_out;
   wmt_pkg::fill_type fill_in;
   logic [18:0]      sum_w;
   logic [6:0]       pages_w;
   logic [32:0]      lim_w, need_w;
   logic [4:0]       flags_w;
   logic             out_free;
   logic             too_big_w, full_w, emit_w;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign sum_w     = {1'b0, req_ff.map_size} + {7'd0, req_ff.paddr[11:0]} + 19'd4095;
   assign pages_w   = sum_w[18:12];
   assign lim_w     = {1'b0, wbase_ff} + {1'b0, wsize_ff};
   assign need_w    = {1'b0, nfv_ff} + {14'd0, pages_w, 12'd0};
   assign flags_w   = 5'h3 | (req_ff.cache_flags & 5'h18);
   assign too_big_w = {25'd0, pages_w} > MAX_PAGES;
   assign full_w    = need_w > lim_w;
   assign emit_w    = out_free &&
                      (((state_ff == PAGES) && (k_ff != pages_ff)) || (state_ff == FINAL));

   always_comb begin
      tok_in            = '0;
      tok_in.live       = (state_ff == IDLE) && req_valid && !(req_data.paddr < ilimit_ff);
      tok_in.pa         = req_data.paddr;
      fill_in           = '0;
      fill_in.phys      = req_ff.paddr;
      fill_in.virt      = nfv_ff + {20'd0, req_ff.paddr[11:0]};
      fill_in.len       = req_ff.map_size;
   end

   logic fill_en_ff;
   wmt_pkg::fill_type fill_w;
   always_comb begin
      fill_w    = fill_in;
      fill_w.en = fill_en_ff;
   end

   wmt_chain #(.SLOT_COUNT(SLOT_COUNT)) u_chain (
      .clock  (clock),
      .reset  (reset),
      .tok_i  (tok_in),
      .fill_i (fill_w),
      .tok_o  (tok_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         fill_en_ff   <= 1'b0;
         ilimit_ff    <= wmt_pkg::IdentityLimitReset;
         kbase_ff     <= wmt_pkg::KernelBaseReset;
         wbase_ff     <= wmt_pkg::WindowBaseReset;
         wsize_ff     <= wmt_pkg::WindowSizeReset;
         nfv_ff       <= wmt_pkg::WindowBaseReset;
      end else begin
         fill_en_ff <= (state_ff == DECIDE) && !too_big_w && !full_w;
         if (emit_w) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               wmt_pkg::CSR_IDENTITY_LIMIT: ilimit_ff <= csr_data;
               wmt_pkg::CSR_KERNEL_BASE:    kbase_ff  <= csr_data;
               wmt_pkg::CSR_WINDOW_BASE:    wbase_ff  <= csr_data;
               default:                     wsize_ff  <= csr_data;
            endcase
         end
         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= SEARCH;
               end
            end
            SEARCH: begin
               if (req_ff.paddr < ilimit_ff) begin
                  virt_ff   <= kbase_ff + req_ff.paddr;
                  status_ff <= wmt_pkg::ST_IDENTITY;
                  state_ff  <= FINAL;
               end else if (tok_out.live) begin
                  if (tok_out.hit) begin
                     virt_ff   <= tok_out.virt;
                     status_ff <= wmt_pkg::ST_EXISTING;
                     state_ff  <= FINAL;
                  end else if (req_ff.op == wmt_pkg::OP_LOOKUP) begin
                     virt_ff   <= '0;
                     status_ff <= wmt_pkg::ST_NOT_FOUND;
                     state_ff  <= FINAL;
                  end else if (!tok_out.free_found) begin
                     virt_ff   <= '0;
                     status_ff <= wmt_pkg::ST_NO_SLOT;
                     state_ff  <= FINAL;
                  end else begin
                     state_ff  <= DECIDE;
                  end
               end
            end
            DECIDE: begin
               if (too_big_w) begin
                  virt_ff   <= '0;
                  status_ff <= wmt_pkg::ST_TOO_LARGE;
                  state_ff  <= FINAL;
               end else if (full_w) begin
                  virt_ff   <= '0;
                  status_ff <= wmt_pkg::ST_FULL;
                  state_ff  <= FINAL;
               end else begin
                  status_ff <= wmt_pkg::ST_NEW;
                  virt_ff   <= fill_in.virt;
                  pages_ff  <= pages_w;
                  k_ff      <= '0;
                  state_ff  <= PAGES;
               end
            end
            PAGES: begin
               if (out_free) begin
                  if (k_ff == pages_ff) begin
                     nfv_ff   <= need_w[31:0];
                     state_ff <= FINAL;
                  end else begin
                     rsp_ff.kind         <= 1'b0;
                     rsp_ff.page_phys    <= {req_ff.paddr[31:12] + {13'd0, k_ff}, 12'd0};
                     rsp_ff.page_virt    <= nfv_ff + {13'd0, k_ff, 12'd0};
                     rsp_ff.pte_flags    <= flags_w;
                     rsp_ff.vaddr        <= '0;
                     rsp_ff.status       <= '0;
                     rsp_ff.last         <= 1'b0;
                     k_ff                <= k_ff + 7'd1;
                  end
               end
            end
            default: begin
               if (out_free) begin
                  rsp_ff.kind       <= 1'b1;
                  rsp_ff.page_phys  <= '0;
                  rsp_ff.page_virt  <= '0;
                  rsp_ff.pte_flags  <= '0;
                  rsp_ff.vaddr      <= virt_ff;
                  rsp_ff.status     <= status_ff;
                  rsp_ff.last       <= 1'b1;
                  state_ff          <= IDLE;
               end
            end
         endcase
      end
   end
endmodule

// File: rtl/core/wmt_checker.sv
// ----------------------------------------------------------------------------
// wmt_checker
// Port checks for the window mapping table unit.
// ----------------------------------------------------------------------------
`include "window_mapping_table_unit_macros.svh"
module wmt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input wmt_pkg::rsp_type rsp_data
);
   logic rsp_wait_w, page_word_w;

   assign rsp_wait_w  = rsp_valid && rsp_stall;
   assign page_word_w = rsp_valid && !rsp_data.kind;

   `WMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait_w, rsp_valid && $stable(rsp_data))
   `WMT_ASSERT_IMPL(a_last_kind, clock, reset, rsp_valid, rsp_data.last == rsp_data.kind)
   `WMT_ASSERT_IMPL(a_page_flags, clock, reset, page_word_w, rsp_data.pte_flags[1:0] == 2'b11)
   `WMT_ASSERT_NEXT(a_busy_after, clock, reset, req_valid && !req_stall, req_stall)
endmodule

bind window_mapping_table_unit wmt_checker u_wmt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
